// ===== rtl/mrqs_pkg.sv =====
// shared types, constants and helpers of the multicore ready-queue scheduler
package mrqs_pkg;

  localparam int NUM_CPUS_DEF    = 4;
  localparam int PRIO_LEVELS_DEF = 32;
  localparam int MAX_THREADS_DEF = 64;

  localparam int IDEAL_W = 4;

  localparam logic [2:0] MODE_LOAD    = 3'd0;
  localparam logic [2:0] MODE_READY   = 3'd1;
  localparam logic [2:0] MODE_TICK    = 3'd2;
  localparam logic [2:0] MODE_YIELD   = 3'd3;
  localparam logic [2:0] MODE_PREEMPT = 3'd4;

  localparam logic [1:0] REG_ACTIVE = 2'd0;
  localparam logic [1:0] REG_THRESH = 2'd1;
  localparam logic [1:0] REG_DPMAX  = 2'd2;

  localparam logic [2:0] ACTIVE_RST = 3'd4;
  localparam logic [5:0] THRESH_RST = 6'd2;
  localparam logic [4:0] DPMAX_RST  = 5'd15;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] cpu;
    logic [5:0] thread;
    logic [4:0] base_priority;
    logic [4:0] start_priority;
    logic [7:0] quantum_length;
    logic [1:0] home_cpu;
    logic       idle_flag;
  } in_item_t;

  typedef struct packed {
    logic [5:0] running_thread;
    logic [5:0] previous_thread;
    logic       switched;
    logic       kick_valid;
    logic [1:0] kick_cpu;
    logic       queue_full;
  } out_item_t;

  typedef struct packed {
    logic [4:0]         prio;
    logic [4:0]         base;
    logic [7:0]         qlen;
    logic [7:0]         qleft;
    logic [IDEAL_W-1:0] ideal;
    logic               is_idle;
  } thread_rec_t;

  function automatic logic [4:0] top_level(input logic [31:0] bits);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (bits[i]) p = 5'(i);
    end
    return p;
  endfunction

endpackage

// ===== rtl/mrqs_ram.sv =====
// single-port-write, single-port-read synchronous ram with registered read data
module mrqs_ram import mrqs_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int DW    = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/multicore_priority_ready_queue_scheduler.sv =====
// top level of the multicore priority ready-queue scheduler with work stealing
//
// in_data carries one scheduler event (load thread, make ready, tick, yield,
// preemption check) for one cpu; a transfer happens when in_valid and in_ready
// are high. Each event gives exactly one result on out_data, with out_valid and
// out_ready. Configuration (active cpus, migration threshold, decay limit) is
// written through the apb port at byte addresses 0, 4 and 8.
// Events are handled one at a time by a sequencer around three rams: the
// thread table, the link table and the per-cpu per-level head/tail table.
// Every ram has registered read data, so a read is used in a later state. The
// shortest events are unknown modes and loads; the longest is a tick at
// quantum end with a least-load scan, an insert and a steal scan. in_ready
// is high while the sequencer is idle.
// The result sits in an output register: the next event is taken while it
// waits, and a stalled receiver holds the sequencer only at its last step.
// Reset clears bitmaps, counts and queue membership, sets each cpu's running
// thread to its own index and restores the register defaults; no clearing
// pass is needed, so events are taken right after reset.
module multicore_priority_ready_queue_scheduler import mrqs_pkg::*; #(
  parameter int NUM_CPUS    = NUM_CPUS_DEF,
  parameter int PRIO_LEVELS = PRIO_LEVELS_DEF,
  parameter int MAX_THREADS = MAX_THREADS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW     = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int TW     = $clog2(MAX_THREADS);
  localparam int PW     = $clog2(PRIO_LEVELS);
  localparam int NW     = $clog2(NUM_CPUS + 1);
  localparam int CNTW   = $clog2(MAX_THREADS + 1);
  localparam int QAW    = CW + PW;
  localparam int QDEPTH = 1 << QAW;
  localparam int RECW   = $bits(thread_rec_t);

  typedef enum logic [20:0] {
    S_IDLE  = 21'd1 << 0,
    S_LOAD  = 21'd1 << 1,
    S_CUR   = 21'd1 << 2,
    S_PRE   = 21'd1 << 3,
    S_PRE2  = 21'd1 << 4,
    S_TSEL  = 21'd1 << 5,
    S_TFIN  = 21'd1 << 6,
    S_SETC  = 21'd1 << 7,
    S_YLD   = 21'd1 << 8,
    S_I0    = 21'd1 << 9,
    S_I1    = 21'd1 << 10,
    S_ISCAN = 21'd1 << 11,
    S_IDEC  = 21'd1 << 12,
    S_IQ    = 21'd1 << 13,
    S_IW    = 21'd1 << 14,
    S_SEL   = 21'd1 << 15,
    S_SSCAN = 21'd1 << 16,
    S_P0    = 21'd1 << 17,
    S_P1    = 21'd1 << 18,
    S_P2    = 21'd1 << 19,
    S_DONE  = 21'd1 << 20
  } state_t;

  // control state
  state_t                 state_r, state_nxt;
  state_t                 ins_ret_r, ins_ret_nxt;
  state_t                 sel_ret_r, sel_ret_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [2:0]             active_r, active_nxt;
  logic [5:0]             thr_r, thr_nxt;
  logic [4:0]             dpmax_r, dpmax_nxt;
  logic [PRIO_LEVELS-1:0] bitmap_r [NUM_CPUS];
  logic [PRIO_LEVELS-1:0] bitmap_nxt [NUM_CPUS];
  logic [CNTW-1:0]        count_r [NUM_CPUS];
  logic [CNTW-1:0]        count_nxt [NUM_CPUS];
  logic [TW-1:0]          current_r [NUM_CPUS];
  logic [TW-1:0]          current_nxt [NUM_CPUS];
  logic [MAX_THREADS-1:0] queued_r, queued_nxt;

  // working registers
  out_item_t   out_data_r, out_data_nxt;
  logic [2:0]  mode_r, mode_nxt;
  logic [CW-1:0] c_r, c_nxt;
  logic [TW-1:0] t_r, t_nxt;
  logic [TW-1:0] prev_r, prev_nxt;
  in_item_t    item_r, item_nxt;
  thread_rec_t cur_rec_r, cur_rec_nxt;
  thread_rec_t ins_rec_r, ins_rec_nxt;
  logic [TW-1:0] ins_t_r, ins_t_nxt;
  logic        ins_skip_r, ins_skip_nxt;
  logic [CW-1:0] ideal_r, ideal_nxt;
  logic [CW-1:0] target_r, target_nxt;
  logic [CW-1:0] least_r, least_nxt;
  logic [CNTW-1:0] load_r, load_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic [PW-1:0] ins_prio_r, ins_prio_nxt;
  logic        steal_found_r, steal_found_nxt;
  logic [CW-1:0] best_r, best_nxt;
  logic [4:0]  best_prio_r, best_prio_nxt;
  logic        sel_found_r, sel_found_nxt;
  logic [CW-1:0] pop_c_r, pop_c_nxt;
  logic [PW-1:0] pop_prio_r, pop_prio_nxt;
  logic [TW-1:0] pop_tail_r, pop_tail_nxt;
  logic [TW-1:0] next_r, next_nxt;
  logic        kick_r, kick_nxt;
  logic [CW-1:0] kick_cpu_r, kick_cpu_nxt;
  logic        full_r, full_nxt;

  // ram ports
  logic              th_we;
  logic [TW-1:0]     th_waddr, th_raddr;
  thread_rec_t       th_wdata, th_rdata;
  logic              lk_we;
  logic [TW-1:0]     lk_waddr, lk_raddr, lk_wdata, lk_rdata;
  logic              q_we;
  logic [QAW-1:0]    q_waddr, q_raddr;
  logic [2*TW-1:0]   q_wdata, q_rdata;

  // combinational helpers
  logic [CW-1:0]     c_in;
  logic [TW-1:0]     t_in;
  logic [NW-1:0]     act_n;
  logic              scan_last;
  thread_rec_t       rec_mod;
  logic [7:0]        ql_dec;
  logic [PRIO_LEVELS-1:0] sc_bits;
  logic [4:0]        sc_top;
  logic              sc_take;
  logic              sc_found;
  logic [CW-1:0]     sc_best;
  logic [PW-1:0]     pop_top;
  logic [TW-1:0]     q_head, q_tail;
  logic [PW-1:0]     ins_clamp;
  logic              cfg_wr;

  mrqs_ram #(.DEPTH(MAX_THREADS), .DW(RECW)) u_thread_ram (
    .clk   (clk),
    .we    (th_we),
    .waddr (th_waddr),
    .wdata (th_wdata),
    .raddr (th_raddr),
    .rdata (th_rdata)
  );

  mrqs_ram #(.DEPTH(MAX_THREADS), .DW(TW)) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  mrqs_ram #(.DEPTH(QDEPTH), .DW(2 * TW)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_ACTIVE: prdata = {29'd0, active_r};
      REG_THRESH: prdata = {26'd0, thr_r};
      REG_DPMAX:  prdata = {27'd0, dpmax_r};
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    active_nxt = active_r;
    thr_nxt    = thr_r;
    dpmax_nxt  = dpmax_r;
    if (cfg_wr) begin
      case (paddr[3:2])
        REG_ACTIVE: active_nxt = pwdata[2:0];
        REG_THRESH: thr_nxt    = pwdata[5:0];
        REG_DPMAX:  dpmax_nxt  = pwdata[4:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    if (active_r == 3'd0) begin
      act_n = NW'(1);
    end else if (32'(active_r) > NUM_CPUS) begin
      act_n = NW'(NUM_CPUS);
    end else begin
      act_n = NW'(active_r);
    end
  end

  assign c_in      = CW'(in_data.cpu % NUM_CPUS);
  assign t_in      = TW'(in_data.thread % MAX_THREADS);
  assign scan_last = (32'(scan_r) + 32'd1 == 32'(act_n));
  assign q_head    = q_rdata[2*TW-1:TW];
  assign q_tail    = q_rdata[TW-1:0];
  assign pop_top   = PW'(top_level(32'(bitmap_r[pop_c_r])));
  assign ins_clamp = (32'(ins_rec_r.prio) >= PRIO_LEVELS) ? PW'(PRIO_LEVELS - 1)
                                                           : PW'(ins_rec_r.prio);
  assign ql_dec    = th_rdata.qleft - 8'd1;
  assign sc_bits   = bitmap_r[scan_r];
  assign sc_top    = top_level(32'(sc_bits));
  assign sc_take   = (scan_r != c_r) && (sc_bits != '0) &&
                     (!steal_found_r || (sc_top > best_prio_r));
  assign sc_found  = steal_found_r || sc_take;
  assign sc_best   = sc_take ? scan_r : best_r;

  always_comb begin
    state_nxt       = state_r;
    ins_ret_nxt     = ins_ret_r;
    sel_ret_nxt     = sel_ret_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_data_nxt    = out_data_r;
    bitmap_nxt      = bitmap_r;
    count_nxt       = count_r;
    current_nxt     = current_r;
    queued_nxt      = queued_r;
    mode_nxt        = mode_r;
    c_nxt           = c_r;
    t_nxt           = t_r;
    prev_nxt        = prev_r;
    item_nxt        = item_r;
    cur_rec_nxt     = cur_rec_r;
    ins_rec_nxt     = ins_rec_r;
    ins_t_nxt       = ins_t_r;
    ins_skip_nxt    = ins_skip_r;
    ideal_nxt       = ideal_r;
    target_nxt      = target_r;
    least_nxt       = least_r;
    load_nxt        = load_r;
    scan_nxt        = scan_r;
    ins_prio_nxt    = ins_prio_r;
    steal_found_nxt = steal_found_r;
    best_nxt        = best_r;
    best_prio_nxt   = best_prio_r;
    sel_found_nxt   = sel_found_r;
    pop_c_nxt       = pop_c_r;
    pop_prio_nxt    = pop_prio_r;
    pop_tail_nxt    = pop_tail_r;
    next_nxt        = next_r;
    kick_nxt        = kick_r;
    kick_cpu_nxt    = kick_cpu_r;
    full_nxt        = full_r;
    rec_mod         = th_rdata;

    th_we    = 1'b0;
    th_waddr = ins_t_r;
    th_wdata = ins_rec_r;
    th_raddr = ins_t_r;
    lk_we    = 1'b0;
    lk_waddr = q_tail;
    lk_wdata = ins_t_r;
    lk_raddr = q_head;
    q_we     = 1'b0;
    q_waddr  = {target_r, ins_prio_r};
    q_wdata  = {ins_t_r, ins_t_r};
    q_raddr  = {pop_c_r, pop_top};

    case (state_r)
      S_IDLE: begin
        th_raddr = current_r[c_in];
        if (in_valid) begin
          item_nxt      = in_data;
          mode_nxt      = in_data.mode;
          c_nxt         = c_in;
          t_nxt         = t_in;
          prev_nxt      = current_r[c_in];
          kick_nxt      = 1'b0;
          kick_cpu_nxt  = '0;
          full_nxt      = 1'b0;
          sel_found_nxt = 1'b0;
          case (in_data.mode)
            MODE_LOAD: state_nxt = S_LOAD;
            MODE_READY: begin
              ins_t_nxt    = t_in;
              ins_skip_nxt = 1'b0;
              ins_ret_nxt  = S_DONE;
              state_nxt    = S_I0;
            end
            MODE_TICK, MODE_YIELD, MODE_PREEMPT: state_nxt = S_CUR;
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_LOAD: begin
        th_we            = 1'b1;
        th_waddr         = t_r;
        th_wdata.prio    = item_r.start_priority;
        th_wdata.base    = item_r.base_priority;
        th_wdata.qlen    = item_r.quantum_length;
        th_wdata.qleft   = item_r.quantum_length;
        th_wdata.ideal   = IDEAL_W'(item_r.home_cpu % NUM_CPUS);
        th_wdata.is_idle = item_r.idle_flag;
        state_nxt        = S_DONE;
      end

      S_CUR: begin
        cur_rec_nxt = th_rdata;
        case (mode_r)
          MODE_TICK: begin
            if (th_rdata.is_idle) begin
              sel_ret_nxt = S_SETC;
              state_nxt   = S_SEL;
            end else if (ql_dec != 8'd0) begin
              rec_mod.qleft = ql_dec;
              th_we         = 1'b1;
              th_waddr      = prev_r;
              th_wdata      = rec_mod;
              cur_rec_nxt   = rec_mod;
              state_nxt     = S_PRE;
            end else begin
              rec_mod.qleft = th_rdata.qlen;
              if (th_rdata.prio <= dpmax_r && th_rdata.prio > th_rdata.base) begin
                rec_mod.prio = th_rdata.prio - 5'd1;
              end
              th_we        = 1'b1;
              th_waddr     = prev_r;
              th_wdata     = rec_mod;
              cur_rec_nxt  = rec_mod;
              ins_t_nxt    = prev_r;
              ins_skip_nxt = 1'b0;
              ins_ret_nxt  = S_TSEL;
              state_nxt    = S_I0;
            end
          end
          MODE_YIELD: begin
            sel_ret_nxt = S_YLD;
            state_nxt   = S_SEL;
          end
          default: state_nxt = S_PRE;
        endcase
      end

      S_PRE: begin
        if (bitmap_r[c_r] != '0 &&
            top_level(32'(bitmap_r[c_r])) > cur_rec_r.prio) begin
          pop_c_nxt   = c_r;
          sel_ret_nxt = S_PRE2;
          state_nxt   = S_P0;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_PRE2: begin
        current_nxt[c_r] = next_r;
        ins_t_nxt        = prev_r;
        ins_skip_nxt     = 1'b1;
        ins_ret_nxt      = S_DONE;
        state_nxt        = S_I0;
      end

      S_TSEL: begin
        sel_ret_nxt = S_TFIN;
        state_nxt   = S_SEL;
      end

      S_TFIN: begin
        current_nxt[c_r] = sel_found_r ? next_r : TW'(c_r % MAX_THREADS);
        state_nxt        = S_DONE;
      end

      S_SETC: begin
        if (sel_found_r) begin
          current_nxt[c_r] = next_r;
        end
        state_nxt = S_DONE;
      end

      S_YLD: begin
        if (!sel_found_r) begin
          state_nxt = S_DONE;
        end else if (next_r == prev_r) begin
          ins_t_nxt    = next_r;
          ins_skip_nxt = 1'b0;
          ins_ret_nxt  = S_DONE;
          state_nxt    = S_I0;
        end else begin
          current_nxt[c_r] = next_r;
          ins_t_nxt        = prev_r;
          ins_skip_nxt     = 1'b1;
          ins_ret_nxt      = S_DONE;
          state_nxt        = S_I0;
        end
      end

      S_I0: begin
        state_nxt = S_I1;
      end

      S_I1: begin
        if (ins_skip_r && th_rdata.is_idle) begin
          state_nxt = ins_ret_r;
        end else if (queued_r[ins_t_r]) begin
          full_nxt  = 1'b1;
          state_nxt = ins_ret_r;
        end else begin
          ins_rec_nxt = th_rdata;
          ideal_nxt   = CW'(th_rdata.ideal % NUM_CPUS);
          target_nxt  = CW'(th_rdata.ideal % NUM_CPUS);
          scan_nxt    = '0;
          state_nxt   = (act_n > NW'(1)) ? S_ISCAN : S_IQ;
        end
      end

      S_ISCAN: begin
        if (scan_r == '0 || count_r[scan_r] < load_r) begin
          least_nxt = scan_r;
          load_nxt  = count_r[scan_r];
        end
        if (scan_last) begin
          state_nxt = S_IDEC;
        end else begin
          scan_nxt = scan_r + CW'(1);
        end
      end

      S_IDEC: begin
        if (32'(count_r[ideal_r]) >= 32'(count_r[least_r]) + 32'(thr_r)) begin
          target_nxt        = least_r;
          ins_rec_nxt.ideal = IDEAL_W'(least_r);
          th_we             = 1'b1;
          th_waddr          = ins_t_r;
          th_wdata          = ins_rec_r;
          th_wdata.ideal    = IDEAL_W'(least_r);
        end
        state_nxt = S_IQ;
      end

      S_IQ: begin
        ins_prio_nxt = ins_clamp;
        q_raddr      = {target_r, ins_clamp};
        state_nxt    = S_IW;
      end

      S_IW: begin
        q_we    = 1'b1;
        q_waddr = {target_r, ins_prio_r};
        if (bitmap_r[target_r][ins_prio_r]) begin
          lk_we    = 1'b1;
          lk_waddr = q_tail;
          lk_wdata = ins_t_r;
          q_wdata  = {q_head, ins_t_r};
        end else begin
          q_wdata  = {ins_t_r, ins_t_r};
        end
        bitmap_nxt[target_r][ins_prio_r] = 1'b1;
        count_nxt[target_r] = count_r[target_r] + CNTW'(1);
        queued_nxt[ins_t_r] = 1'b1;
        if (target_r != c_r) begin
          kick_nxt     = 1'b1;
          kick_cpu_nxt = target_r;
        end
        state_nxt = ins_ret_r;
      end

      S_SEL: begin
        sel_found_nxt   = 1'b0;
        steal_found_nxt = 1'b0;
        scan_nxt        = '0;
        if (bitmap_r[c_r] != '0) begin
          pop_c_nxt = c_r;
          state_nxt = S_P0;
        end else begin
          state_nxt = S_SSCAN;
        end
      end

      S_SSCAN: begin
        if (sc_take) begin
          steal_found_nxt = 1'b1;
          best_nxt        = scan_r;
          best_prio_nxt   = sc_top;
        end
        if (scan_last) begin
          if (sc_found) begin
            pop_c_nxt = sc_best;
            state_nxt = S_P0;
          end else begin
            state_nxt = sel_ret_r;
          end
        end else begin
          scan_nxt = scan_r + CW'(1);
        end
      end

      S_P0: begin
        pop_prio_nxt = pop_top;
        q_raddr      = {pop_c_r, pop_top};
        state_nxt    = S_P1;
      end

      S_P1: begin
        next_nxt        = q_head;
        pop_tail_nxt    = q_tail;
        sel_found_nxt   = 1'b1;
        queued_nxt[q_head] = 1'b0;
        if (count_r[pop_c_r] != '0) begin
          count_nxt[pop_c_r] = count_r[pop_c_r] - CNTW'(1);
        end
        if (q_head == q_tail) begin
          bitmap_nxt[pop_c_r][pop_prio_r] = 1'b0;
          state_nxt = sel_ret_r;
        end else begin
          lk_raddr  = q_head;
          state_nxt = S_P2;
        end
      end

      S_P2: begin
        q_we      = 1'b1;
        q_waddr   = {pop_c_r, pop_prio_r};
        q_wdata   = {lk_rdata, pop_tail_r};
        state_nxt = sel_ret_r;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.running_thread  = 6'(current_r[c_r]);
          out_data_nxt.previous_thread = 6'(prev_r);
          out_data_nxt.switched        = (current_r[c_r] != prev_r);
          out_data_nxt.kick_valid      = kick_r;
          out_data_nxt.kick_cpu        = kick_r ? 2'(kick_cpu_r) : 2'd0;
          out_data_nxt.queue_full      = full_r;
          state_nxt                    = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ins_ret_r   <= S_DONE;
      sel_ret_r   <= S_DONE;
      out_valid_r <= 1'b0;
      active_r    <= ACTIVE_RST;
      thr_r       <= THRESH_RST;
      dpmax_r     <= DPMAX_RST;
      queued_r    <= '0;
      for (int i = 0; i < NUM_CPUS; i++) begin
        bitmap_r[i]  <= '0;
        count_r[i]   <= '0;
        current_r[i] <= TW'(i % MAX_THREADS);
      end
    end else begin
      state_r     <= state_nxt;
      ins_ret_r   <= ins_ret_nxt;
      sel_ret_r   <= sel_ret_nxt;
      out_valid_r <= out_valid_nxt;
      active_r    <= active_nxt;
      thr_r       <= thr_nxt;
      dpmax_r     <= dpmax_nxt;
      queued_r    <= queued_nxt;
      bitmap_r    <= bitmap_nxt;
      count_r     <= count_nxt;
      current_r   <= current_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r    <= out_data_nxt;
    mode_r        <= mode_nxt;
    c_r           <= c_nxt;
    t_r           <= t_nxt;
    prev_r        <= prev_nxt;
    item_r        <= item_nxt;
    cur_rec_r     <= cur_rec_nxt;
    ins_rec_r     <= ins_rec_nxt;
    ins_t_r       <= ins_t_nxt;
    ins_skip_r    <= ins_skip_nxt;
    ideal_r       <= ideal_nxt;
    target_r      <= target_nxt;
    least_r       <= least_nxt;
    load_r        <= load_nxt;
    scan_r        <= scan_nxt;
    ins_prio_r    <= ins_prio_nxt;
    steal_found_r <= steal_found_nxt;
    best_r        <= best_nxt;
    best_prio_r   <= best_prio_nxt;
    sel_found_r   <= sel_found_nxt;
    pop_c_r       <= pop_c_nxt;
    pop_prio_r    <= pop_prio_nxt;
    pop_tail_r    <= pop_tail_nxt;
    next_r        <= next_nxt;
    kick_r        <= kick_nxt;
    kick_cpu_r    <= kick_cpu_nxt;
    full_r        <= full_nxt;
  end

  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while an event is in work");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) && (bitmap_r[0] == '0) |-> (count_r[0] == '0))
    else $error("ready count of cpu 0 nonzero with empty bitmap");

  a_kick_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.kick_valid && out_data_r.queue_full))
    else $error("one event both refused and kicked a cpu");

endmodule
